// File: src/bfi_pkg.sv
package bfi_pkg;

   localparam int MAX_BITS_DEF = 65536;
   localparam int KEY_W        = 32;
   localparam int FUNC_W       = 2;
   localparam int PROBES_W     = 5;
   localparam int FBITS_W      = 17;
   localparam int ROT_RIGHT    = 17;
   localparam int MOD_STEPS    = 4;

   localparam logic [PROBES_W-1:0] PROBES_RST = 5'd6;
   localparam logic [PROBES_W-1:0] PROBES_MAX = 5'd30;
   localparam logic [FBITS_W-1:0]  FBITS_RST  = 17'd65536;
   localparam logic [FBITS_W-1:0]  FBITS_MIN  = 17'd64;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic CSR_NUM_PROBES  = 1'b0;
   localparam logic CSR_FILTER_BITS = 1'b1;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key_hash;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_MOD,
      ST_READ,
      ST_RMW
   } back_state_type;

endpackage

// File: src/bfi_front.sv
module bfi_front import bfi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    hold,
   input  logic    push,
   output logic    full,
   input  cmd_type cmd_in,
   input  logic    cmd_pop,
   output logic    cmd_valid,
   output cmd_type cmd_out
);

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        wr_en, rd_en;

   assign full      = (count_ff == 2'd2) || hold;
   assign wr_en     = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign rd_en     = cmd_pop && cmd_valid;
   assign cmd_out   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// File: src/bfi_mod.sv
module bfi_mod import bfi_pkg::*; #(
   parameter int BW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [KEY_W-1:0] dividend,
   input  logic [BW-1:0] divisor,
   output logic          done,
   output logic [BW-1:0] rem
);

   localparam int ITER  = KEY_W / MOD_STEPS;
   localparam int CNT_W = $clog2(ITER);

   logic [BW-1:0]    rem_ff, rem_in;
   logic [KEY_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   // restoring remainder, MOD_STEPS dividend bits a cycle, MSB first
   always_comb begin
      logic [BW:0] shifted;
      logic [BW:0] trial;
      rem_in = rem_ff;
      q_in   = q_ff;
      for (int i = 0; i < MOD_STEPS; i++) begin
         shifted = {rem_in, q_in[KEY_W-1]};
         trial   = shifted - {1'b0, divisor};
         if (!trial[BW]) begin
            rem_in = trial[BW-1:0];
         end else begin
            rem_in = shifted[BW-1:0];
         end
         q_in = {q_in[KEY_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ITER - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         q_ff   <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// File: src/bfi_back.sv
module bfi_back import bfi_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   input  logic [PROBES_W-1:0] probes,
   input  logic [$clog2(MAX_BITS):0] bits,
   output logic                init_busy,
   output logic                rsp_valid,
   output logic                rsp_match,
   input  logic                rsp_pop
);

   localparam int BW          = $clog2(MAX_BITS) + 1;
   localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
   localparam int AW          = $clog2(STORE_BYTES);

   logic [7:0] mem [STORE_BYTES];

   back_state_type      state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff;
   logic [KEY_W-1:0]    h_ff;
   logic [KEY_W-1:0]    delta_ff;
   logic [PROBES_W-1:0] left_ff;
   logic [AW-1:0]       addr_ff;
   logic [2:0]          bitsel_ff;
   logic [7:0]          rd_ff;
   logic [AW-1:0]       clr_addr_ff;
   logic                clr_op_ff;
   logic                rsp_valid_ff;
   logic                rsp_match_ff;

   logic          mod_start;
   logic          mod_done;
   logic [BW-1:0] mod_rem;

   logic          clr_last;
   logic          probe_bit;
   logic          probe_end;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          finish;
   logic          fin_match;

   bfi_mod #(.BW(BW)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (h_ff),
      .divisor  (bits),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   assign clr_last  = (clr_addr_ff == AW'(STORE_BYTES - 1));
   assign probe_bit = rd_ff[bitsel_ff];
   assign probe_end = (left_ff == PROBES_W'(1)) || ((func_ff == FUNC_QUERY) && !probe_bit);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               if (cmd.func == FUNC_INSERT || cmd.func == FUNC_QUERY) begin
                  state_in = ST_START;
               end else if (cmd.func == FUNC_CLEAR) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_START: state_in = ST_MOD;
         ST_MOD: begin
            if (mod_done) state_in = ST_READ;
         end
         ST_READ: state_in = ST_RMW;
         ST_RMW:  state_in = probe_end ? ST_IDLE : ST_START;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop   = 1'b0;
      mod_start = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = rd_ff | (8'd1 << bitsel_ff);
      finish    = 1'b0;
      fin_match = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = 8'd0;
            finish    = clr_last && clr_op_ff;
         end
         ST_IDLE: begin
            cmd_pop = cmd_valid && !rsp_valid_ff;
            // unused code: store untouched, answer at once
            finish  = cmd_pop && (cmd.func != FUNC_INSERT) && (cmd.func != FUNC_QUERY)
                      && (cmd.func != FUNC_CLEAR);
         end
         ST_START: mod_start = 1'b1;
         ST_RMW: begin
            mem_we    = (func_ff == FUNC_INSERT);
            finish    = probe_end;
            fin_match = (func_ff == FUNC_QUERY) && probe_bit;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_op_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (cmd_pop) begin
            clr_addr_ff <= '0;
            clr_op_ff   <= 1'b1;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         func_ff  <= cmd.func;
         h_ff     <= cmd.key_hash;
         delta_ff <= {cmd.key_hash[ROT_RIGHT-1:0], cmd.key_hash[KEY_W-1:ROT_RIGHT]};
         left_ff  <= probes;
      end
      if (mod_done) begin
         addr_ff   <= mod_rem[AW+2:3];
         bitsel_ff <= mod_rem[2:0];
      end
      if (state_ff == ST_RMW) begin
         h_ff    <= h_ff + delta_ff;
         left_ff <= left_ff - 1'b1;
      end
      if (finish) begin
         rsp_match_ff <= fin_match;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[addr_ff];
   end

   assign init_busy = (state_ff == ST_CLEAR) && !clr_op_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_match = rsp_match_ff;

endmodule

// File: src/bloom_filter_insert_query_core.sv
// Insert and query run num_probes probes between acceptance and result, fewer when a
// query stops at its first clear bit. Each probe: a start state, the 4-bit-per-cycle
// remainder unit (8 steps, then done), a read and the read-modify-write.
// Clear sweeps the byte store one address a cycle.
// Reset is synchronous; after it the same sweep runs with full held high.
// A two-word command queue and a one-word result register decouple the ports.
module bloom_filter_insert_query_core import bfi_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [KEY_W-1:0]    req_key_hash,
   output logic                empty,
   input  logic                pop,
   output logic                rsp_may_match,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [FBITS_W-1:0]  csr_wdata
);

   localparam int BW = $clog2(MAX_BITS) + 1;
   localparam int CW = (BW > FBITS_W) ? BW : FBITS_W;

   logic [PROBES_W-1:0] num_probes_ff;
   logic [FBITS_W-1:0]  filter_bits_ff;
   logic [PROBES_W-1:0] eff_probes;
   logic [BW-1:0]       eff_bits;
   logic [CW-1:0]       bits_wide;

   cmd_type cmd_in;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    init_busy;
   logic    rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_probes_ff  <= PROBES_RST;
         filter_bits_ff <= FBITS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_PROBES:  num_probes_ff  <= csr_wdata[PROBES_W-1:0];
            CSR_FILTER_BITS: filter_bits_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // clamp probes to 1..30 and size to 64..MAX_BITS, whole bytes only
   always_comb begin
      eff_probes = num_probes_ff;
      if (num_probes_ff == '0) eff_probes = PROBES_W'(1);
      if (num_probes_ff > PROBES_MAX) eff_probes = PROBES_MAX;
      bits_wide = CW'({filter_bits_ff[FBITS_W-1:3], 3'b000});
      if (bits_wide < CW'(FBITS_MIN)) bits_wide = CW'(FBITS_MIN);
      if (bits_wide > CW'(MAX_BITS)) bits_wide = CW'(MAX_BITS);
      eff_bits = bits_wide[BW-1:0];
   end

   assign cmd_in.func     = req_func;
   assign cmd_in.key_hash = req_key_hash;

   bfi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .hold      (init_busy),
      .push      (push),
      .full      (full),
      .cmd_in    (cmd_in),
      .cmd_pop   (cmd_pop),
      .cmd_valid (cmd_valid),
      .cmd_out   (cmd)
   );

   bfi_back #(.MAX_BITS(MAX_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .probes    (eff_probes),
      .bits      (eff_bits),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_match (rsp_may_match),
      .rsp_pop   (pop)
   );

   assign empty = !rsp_valid;

endmodule

// File: verif/tb_bloom_filter_insert_query_core.sv
`timescale 1ns / 100ps

module tb_bloom_filter_insert_query_core;
   import bfi_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 700;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key_hash;
   } filter_op_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic [FUNC_W-1:0]   req_func = FUNC_INSERT;
   logic [KEY_W-1:0]    req_key_hash = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic                rsp_may_match;
   logic                csr_we = 1'b0;
   logic                csr_index = CSR_NUM_PROBES;
   logic [FBITS_W-1:0]  csr_wdata = '0;

   filter_op_t          pending_ops[$];
   bit                  match_expect_q[$];
   bit                  filter_bits_model[0:MAX_BITS_DEF-1];
   logic [PROBES_W-1:0] probes_reg;
   logic [FBITS_W-1:0]  fbits_reg;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   logic                recv_hold = 1'b0;
   int                  errors = 0;
   int                  cycles = 0;
   int                  words_in = 0;
   int                  words_out = 0;
   int                  query_hits = 0;
   int                  clears_seen = 0;
   logic [KEY_W-1:0]    key_pool[$];

   bloom_filter_insert_query_core DUT (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_func(req_func), .req_key_hash(req_key_hash),
      .empty(empty), .pop(pop), .rsp_may_match(rsp_may_match),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Apply one operation to the filter copy and return the expected match flag.
   function automatic bit apply_filter_op(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key);
      int unsigned k;
      int unsigned nbits;
      logic [31:0] h;
      logic [31:0] delta;
      int unsigned pos;
      bit          hit;
      k = probes_reg;
      if (k < 1) k = 1;
      if (k > 30) k = 30;
      nbits = fbits_reg & ~32'd7;
      if (nbits < 64) nbits = 64;
      if (nbits > MAX_BITS_DEF) nbits = MAX_BITS_DEF;
      h = key;
      delta = {key[16:0], key[31:17]};
      hit = 1'b0;
      if (func == FUNC_INSERT) begin
         for (int j = 0; j < k; j++) begin
            pos = h % nbits;
            filter_bits_model[pos] = 1'b1;
            h = h + delta;
         end
      end else if (func == FUNC_QUERY) begin
         hit = 1'b1;
         for (int j = 0; j < k; j++) begin
            pos = h % nbits;
            if (!filter_bits_model[pos]) hit = 1'b0;
            h = h + delta;
         end
      end else if (func == FUNC_CLEAR) begin
         foreach (filter_bits_model[i]) filter_bits_model[i] = 1'b0;
      end
      return hit;
   endfunction

   // Driver: offer the next pending word once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || !full) begin
         if (push) begin
            match_expect_q = {match_expect_q, apply_filter_op(req_func, req_key_hash)};
            words_in++;
            if (req_func == FUNC_CLEAR) clears_seen++;
         end
         if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            filter_op_t op;
            op = pending_ops.pop_front();
            req_func     <= op.func;
            req_key_hash <= op.key_hash;
            push         <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Monitor: compare each popped word with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            words_out++;
            if (match_expect_q.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual may_match=%0b",
                        $realtime, rsp_may_match);
               errors++;
            end else begin
               bit exp_match;
               exp_match = match_expect_q.pop_front();
               if (exp_match) query_hits++;
               if (rsp_may_match !== exp_match) begin
                  $display("%0t: may_match mismatch, expected %0b, actual %0b",
                           $realtime, exp_match, rsp_may_match);
                  errors++;
               end
            end
         end
         pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, match_expect_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_config(input logic [PROBES_W-1:0] probes, input logic [FBITS_W-1:0] fbits);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_NUM_PROBES;
      csr_wdata <= FBITS_W'(probes);
      @(posedge clock);
      csr_index <= CSR_FILTER_BITS;
      csr_wdata <= fbits;
      @(posedge clock);
      csr_we    <= 1'b0;
      probes_reg = probes;
      fbits_reg  = fbits;
   endtask

   task automatic add_op(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key);
      filter_op_t op;
      op.func     = func;
      op.key_hash = key;
      pending_ops = {pending_ops, op};
   endtask

   task automatic drain();
      wait (pending_ops.size() == 0 && !push && match_expect_q.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   // Mostly insert-then-query traffic over a small key pool, plus noise.
   task automatic add_random_ops(input int count);
      int r;
      logic [KEY_W-1:0] key;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(999);
         key = $urandom;
         if (r < 5) begin
            add_op(FUNC_CLEAR, key);
         end else if (r < 20) begin
            add_op(FUNC_UNUSED, key);
         end else if (r < 400) begin
            add_op(FUNC_INSERT, key);
            if (key_pool.size() >= 64) void'(key_pool.pop_front());
            key_pool = {key_pool, key};
            if ($urandom_range(3) == 0) add_op(FUNC_QUERY, key);
         end else if (r < 750 && key_pool.size() > 0) begin
            add_op(FUNC_QUERY, key_pool[$urandom_range(key_pool.size() - 1)]);
         end else begin
            add_op(FUNC_QUERY, key);
         end
      end
   endtask

   initial begin
      logic [PROBES_W-1:0] cfg_probes[9] = '{5'd0, 5'd31, 5'd1, 5'd30, 5'd6, 5'd3, 5'd12,
                                              5'd2, 5'd4};
      logic [FBITS_W-1:0]  cfg_fbits[9]  = '{17'd0, 17'd65536, 17'd64, 17'd1000, 17'd131071,
                                              17'd515, 17'd65535, 17'd4096, 17'd200};
      int                  cfg_items[9]  = '{150, 80, 250, 80, 250, 250, 200, 250, 170};

      probes_reg = PROBES_RST;
      fbits_reg  = FBITS_RST;
      foreach (filter_bits_model[i]) filter_bits_model[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // hold off until the power-up sweep of the store is done
      @(posedge clock);
      wait (!full);

      // directed: reset settings, field extremes, every operation
      add_op(FUNC_QUERY,  32'h0000_0000);
      add_op(FUNC_INSERT, 32'h0000_0000);
      add_op(FUNC_QUERY,  32'h0000_0000);
      add_op(FUNC_QUERY,  32'hFFFF_FFFF);
      add_op(FUNC_INSERT, 32'hFFFF_FFFF);
      add_op(FUNC_QUERY,  32'hFFFF_FFFF);
      add_op(FUNC_INSERT, 32'hA5A5_5A5A);
      add_op(FUNC_QUERY,  32'hA5A5_5A5A);
      add_op(FUNC_QUERY,  32'h5A5A_A5A5);
      add_op(FUNC_UNUSED, 32'hFFFF_FFFF);
      add_op(FUNC_QUERY,  32'hA5A5_5A5A);
      add_op(FUNC_CLEAR,  32'h1234_5678);
      add_op(FUNC_QUERY,  32'hA5A5_5A5A);
      add_op(FUNC_QUERY,  32'h0000_0000);
      add_op(FUNC_INSERT, 32'h8000_0001);
      add_op(FUNC_QUERY,  32'h8000_0001);
      drain();

      // a tiny filter, then a large one without clearing in between
      write_config(5'd1, 17'd64);
      add_op(FUNC_INSERT, 32'h0000_0100);
      add_op(FUNC_QUERY,  32'h0000_0100);
      drain();
      write_config(5'd1, 17'd65536);
      add_op(FUNC_QUERY,  32'h0000_0100);
      add_op(FUNC_QUERY,  32'h0000_0000);
      drain();

      for (int p = 0; p < 9; p++) begin
         if (p == 8) write_config(5'($urandom_range(1, 8)), 17'($urandom_range(64, 8192)));
         else write_config(cfg_probes[p], cfg_fbits[p]);
         if (p < 3) begin
            send_idle_pct = 36;
            recv_idle_pct = 79;
         end else if (p < 6) begin
            send_idle_pct = 79;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         add_random_ops(cfg_items[p]);
         if (p == 6) begin
            // stall the result side long enough to back up the command queue
            recv_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            recv_hold <= 1'b0;
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("ran %0d words (%0d clears) through 12 filter settings, %0d results checked,",
               words_in, clears_seen, words_out);
      $display("%0d query hits, probe counts 0..31 and sizes 0..131071 included", query_hits);
      if (errors == 0 && match_expect_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
